### design/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared widths, constants, command codes and the Taylor lane record.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int CMD_W   = 2;
    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;

    localparam int TERMS_DEF = 10;

    localparam logic [CMD_W-1:0] CMD_SIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAN = 2'd2;

    // Q52 argument, reduced remainder, Q30 lane values
    localparam int A_W   = 62;
    localparam int R_W   = 57;
    localparam int MAG_W = 32;
    localparam int X2_W  = 32;
    localparam int SUM_W = 34;
    localparam int NH_W  = 34;

    localparam logic signed [63:0] PI_Q60     = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] PI_Q52     = (PI_Q60 + 64'sd128) >>> 8;
    localparam logic signed [63:0] HALFPI_Q52 = (PI_Q60 + 64'sd256) >>> 9;
    localparam logic signed [63:0] TWOPI_Q52  = (PI_Q60 + 64'sd64) >>> 7;

    typedef struct packed {
        logic [CMD_W-1:0]        tag;
        logic [X2_W-1:0]         x2;
        logic [MAG_W-1:0]        mag;
        logic                    neg;
        logic signed [SUM_W-1:0] sum;
    } t_lane;

endpackage

### design/sct_reduce.sv
// ----------------------------------------------------------------------------
// sct_reduce
// Range reduction mod 2*pi, fold to [-pi/2, pi/2], Q30 convert and square.
// ----------------------------------------------------------------------------
module sct_reduce import sct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic signed [A_W-1:0] i_arg,
    output logic                  o_valid,
    output t_lane                 o_lane
);

    localparam logic signed [R_W-1:0] PI_R  = R_W'(PI_Q52);
    localparam logic signed [R_W-1:0] HP_R  = R_W'(HALFPI_Q52);
    localparam logic signed [R_W-1:0] TPI_R = R_W'(TWOPI_Q52);

    logic [7:0]              r_v;
    logic [CMD_W-1:0]        r_tag [0:6];
    logic                    r_neg [0:3];
    logic [A_W-1:0]          r_rm  [0:3];
    logic signed [R_W-1:0]   r_fold;
    logic [MAG_W-1:0]        r_xmag;
    logic                    r_xneg;
    logic [63:0]             r_sq;
    logic [MAG_W-1:0]        r_xmag6;
    logic                    r_xneg6;
    t_lane                   r_lane;

    logic [A_W-1:0]          n_mag0;
    logic [A_W-1:0]          n_rm  [1:3];
    logic signed [R_W-1:0]   n_r;
    logic signed [R_W-1:0]   n_fold;
    logic signed [R_W-1:0]   n_f2;
    logic [R_W-1:0]          n_abs;
    logic [R_W-1:0]          n_rnd;
    logic [63:0]             n_sq;
    t_lane                   n_lane;

    function automatic logic [A_W-1:0] mod_step(input logic [A_W-1:0] v, input int i);
        logic [A_W-1:0] s;
        s = A_W'(TWOPI_Q52) << i;
        mod_step = (v >= s) ? v - s : v;
    endfunction

    always_comb begin
        n_mag0 = i_arg[A_W-1] ? A_W'(-i_arg) : A_W'(i_arg);
        for (int k = 1; k < 4; k++) begin
            n_rm[k] = mod_step(mod_step(r_rm[k-1], 7 - 2*k), 6 - 2*k);
        end

        n_r = $signed({1'b0, r_rm[3][R_W-2:0]});
        if (r_neg[3]) begin
            n_r = -n_r;
        end
        if (n_r > PI_R) begin
            n_fold = n_r - TPI_R;
        end else if (n_r < -PI_R) begin
            n_fold = n_r + TPI_R;
        end else begin
            n_fold = n_r;
        end

        if (r_fold > HP_R) begin
            n_f2 = PI_R - r_fold;
        end else if (r_fold < -HP_R) begin
            n_f2 = -PI_R - r_fold;
        end else begin
            n_f2 = r_fold;
        end
        n_abs = n_f2[R_W-1] ? R_W'(-n_f2) : R_W'(n_f2);
        n_rnd = (n_abs + (R_W'(1) << 21)) >> 22;

        n_sq = 64'(r_xmag) * 64'(r_xmag);

        n_lane.tag = r_tag[6];
        n_lane.x2  = X2_W'((r_sq + (64'd1 << 29)) >> 30);
        n_lane.mag = r_xmag6;
        n_lane.neg = r_xneg6;
        n_lane.sum = r_xneg6 ? -$signed(SUM_W'(r_xmag6)) : $signed(SUM_W'(r_xmag6));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_cmd;
            for (int k = 1; k < 7; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            r_neg[0] <= i_arg[A_W-1];
            r_rm[0]  <= n_mag0;
            for (int k = 1; k < 4; k++) begin
                r_neg[k] <= r_neg[k-1];
                r_rm[k]  <= n_rm[k];
            end
            r_fold  <= n_fold;
            r_xmag  <= MAG_W'(n_rnd);
            r_xneg  <= n_f2[R_W-1];
            r_sq    <= n_sq;
            r_xmag6 <= r_xmag;
            r_xneg6 <= r_xneg;
            r_lane  <= n_lane;
        end
    end

    assign o_valid = r_v[7];
    assign o_lane  = r_lane;

endmodule

### design/sct_term.sv
// ----------------------------------------------------------------------------
// sct_term
// One Taylor term: next = -(term * x^2 / ((2n)(2n+1))), accumulated.
// ----------------------------------------------------------------------------
module sct_term import sct_pkg::*; #(
    parameter int N = 1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    localparam int          DV     = (2*N) * (2*N + 1);
    localparam int          DW     = $clog2(DV + 1);
    localparam logic [31:0] RECIP  = 32'((64'd1 << NH_W) / DV);
    localparam logic [63:0] RND    = 64'(DV) << 29;
    localparam int          M_W    = NH_W + 32;

    logic [4:0]          r_v;
    t_lane               r_lane [0:4];
    logic [63:0]         r_p;
    logic [NH_W-1:0]     r_nh1;
    logic [NH_W-1:0]     r_nh2;
    logic [NH_W-1:0]     r_nh3;
    logic [M_W-1:0]      r_m;
    logic [31:0]         r_q0;
    logic [NH_W-1:0]     r_qd;

    logic [63:0]         n_sum;
    logic [M_W-1:0]      n_m;
    logic [31:0]         n_q0;
    logic [NH_W+DW-1:0]  n_qdw;
    logic [NH_W-1:0]     n_rem;
    logic [31:0]         n_q;
    t_lane               n_lane;

    always_comb begin
        n_sum = r_p + RND;
        n_m   = M_W'(r_nh1) * M_W'(RECIP);
        n_q0  = r_m[M_W-1:NH_W];
        n_qdw = (NH_W+DW)'(n_q0) * (NH_W+DW)'(DV);
        n_rem = r_nh3 - r_qd;
        n_q   = r_q0 + ((n_rem >= NH_W'(DV)) ? 32'd1 : 32'd0);

        n_lane     = r_lane[3];
        n_lane.mag = n_q;
        n_lane.neg = ~r_lane[3].neg;
        n_lane.sum = r_lane[3].neg ? r_lane[3].sum + $signed(SUM_W'(n_q))
                                   : r_lane[3].sum - $signed(SUM_W'(n_q));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane[0] <= i_lane;
            r_lane[1] <= r_lane[0];
            r_lane[2] <= r_lane[1];
            r_lane[3] <= r_lane[2];
            r_lane[4] <= n_lane;
            r_p       <= 64'(i_lane.mag) * 64'(i_lane.x2);
            r_nh1     <= n_sum[NH_W+29:30];
            r_m       <= n_m;
            r_nh2     <= r_nh1;
            r_q0      <= n_q0;
            r_qd      <= n_qdw[NH_W-1:0];
            r_nh3     <= r_nh2;
        end
    end

    assign o_valid = r_v[4];
    assign o_lane  = r_lane[4];

endmodule

### design/sct_eval.sv
// ----------------------------------------------------------------------------
// sct_eval
// Sine evaluator: reduction front end followed by a chain of term stages.
// ----------------------------------------------------------------------------
module sct_eval import sct_pkg::*; #(
    parameter int TERMS = TERMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic signed [A_W-1:0] i_arg,
    output logic                  o_valid,
    output t_lane                 o_lane
);

    logic  w_v    [0:TERMS-1];
    t_lane w_lane [0:TERMS-1];

    sct_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_arg   (i_arg),
        .o_valid (w_v[0]),
        .o_lane  (w_lane[0])
    );

    for (genvar g = 1; g < TERMS; g++) begin : g_term
        sct_term #(.N(g)) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_v[g-1]),
            .i_lane  (w_lane[g-1]),
            .o_valid (w_v[g]),
            .o_lane  (w_lane[g])
        );
    end

    assign o_valid = w_v[TERMS-1];
    assign o_lane  = w_lane[TERMS-1];

endmodule

### design/sct_tan.sv
// ----------------------------------------------------------------------------
// sct_tan
// Output rounding, pipelined restoring divider for tangent, result select.
// ----------------------------------------------------------------------------
module sct_tan import sct_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [SUM_W-1:0] i_sin,
    input  logic signed [SUM_W-1:0] i_cos,
    output logic                    o_valid,
    output logic [VALUE_W-1:0]      o_value,
    output logic                    o_ovf
);

    localparam int QB    = 32;
    localparam int NUM_W = SUM_W + 24;
    localparam int CMP_W = NUM_W + QB;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] sval;
        logic [VALUE_W-1:0] cval;
        logic [NUM_W-1:0]   rem;
        logic [SUM_W-1:0]   den;
        logic [QB-1:0]      quo;
        logic               neg;
        logic               zero;
        logic               spos;
        logic               big;
    } t_div_stage;

    logic [QB:0]        r_v;
    t_div_stage         r_st [0:QB];
    logic               r_ov;
    logic [VALUE_W-1:0] r_val;
    logic               r_ovf;

    t_div_stage         n_st0;
    t_div_stage         n_st [1:QB];
    logic [SUM_W-1:0]   n_sabs;
    logic [SUM_W-1:0]   n_cabs;
    logic [CMP_W-1:0]   n_sh [1:QB];
    logic [VALUE_W-1:0] n_val;
    logic               n_ovf;
    t_div_stage         w_last;

    function automatic logic [VALUE_W-1:0] round6(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] m;
        a = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        m = (a + SUM_W'(32)) >> 6;
        round6 = v[SUM_W-1] ? VALUE_W'(-m) : VALUE_W'(m);
    endfunction

    always_comb begin
        n_sabs     = i_sin[SUM_W-1] ? SUM_W'(-i_sin) : SUM_W'(i_sin);
        n_cabs     = i_cos[SUM_W-1] ? SUM_W'(-i_cos) : SUM_W'(i_cos);
        n_st0.cmd  = i_cmd;
        n_st0.sval = round6(i_sin);
        n_st0.cval = round6(i_cos);
        n_st0.rem  = NUM_W'(n_sabs) << 24;
        n_st0.den  = n_cabs;
        n_st0.quo  = '0;
        n_st0.neg  = i_sin[SUM_W-1] ^ i_cos[SUM_W-1];
        n_st0.zero = (i_cos == '0);
        n_st0.spos = ~i_sin[SUM_W-1];
        n_st0.big  = (CMP_W'(n_sabs) << 24) >= (CMP_W'(n_cabs) << QB);

        for (int k = 1; k <= QB; k++) begin
            n_st[k] = r_st[k-1];
            n_sh[k] = CMP_W'(r_st[k-1].den) << (QB - k);
            if (CMP_W'(r_st[k-1].rem) >= n_sh[k]) begin
                n_st[k].rem          = r_st[k-1].rem - n_sh[k][NUM_W-1:0];
                n_st[k].quo[QB - k]  = 1'b1;
            end
        end

        w_last = r_st[QB];
        n_val  = '0;
        n_ovf  = 1'b0;
        case (w_last.cmd)
            CMD_SIN: n_val = w_last.sval;
            CMD_COS: n_val = w_last.cval;
            CMD_TAN: begin
                if (w_last.zero) begin
                    n_val = w_last.spos ? {1'b0, {(VALUE_W-1){1'b1}}}
                                        : {1'b1, {(VALUE_W-1){1'b0}}};
                    n_ovf = 1'b1;
                end else if (!w_last.neg) begin
                    if (w_last.big || w_last.quo[QB-1]) begin
                        n_val = {1'b0, {(VALUE_W-1){1'b1}}};
                        n_ovf = 1'b1;
                    end else begin
                        n_val = w_last.quo;
                    end
                end else begin
                    if (w_last.big || (w_last.quo[QB-1] && (w_last.quo[QB-2:0] != '0))) begin
                        n_val = {1'b1, {(VALUE_W-1){1'b0}}};
                        n_ovf = 1'b1;
                    end else begin
                        n_val = -w_last.quo;
                    end
                end
            end
            default: begin
                n_val = '0;
                n_ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[QB-1:0], i_valid};
            r_ov <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
            for (int k = 1; k <= QB; k++) begin
                r_st[k] <= n_st[k];
            end
            r_val <= n_val;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid = r_ov;
    assign o_value = r_val;
    assign o_ovf   = r_ovf;

endmodule

### design/sine_cosine_tangent_unit_top.sv
// ----------------------------------------------------------------------------
// sine_cosine_tangent_unit_top
// Pipelined Taylor-series sine / cosine / tangent on Q8.24 angles.
//
//   channel  dir  tdata              tuser
//   s        in   angle (Q8.24)      cmd
//   m        out  value (Q8.24)      overflow
//
// One transfer per cycle sustained while the output is not stalled.
// Depth is set by the five-stage multiply/reciprocal unit of each Taylor
// term and by the one-bit-per-stage tangent divider.
// Synchronous active-low reset clears all valid bits.
// A stalled output register freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module sine_cosine_tangent_unit_top import sct_pkg::*; #(
    parameter int TERMS = TERMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [ANGLE_W-1:0]   i_s_tdata,   // [31:0] angle
    input  logic [CMD_W-1:0]     i_s_tuser,   // [1:0] cmd
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [VALUE_W-1:0]   o_m_tdata,   // [31:0] value
    output logic [0:0]           o_m_tuser    // [0] overflow
);

    logic                  w_en;
    logic signed [A_W-1:0] w_arg_s;
    logic signed [A_W-1:0] w_arg_c;
    logic                  w_sv;
    logic                  w_cv;
    t_lane                 w_sl;
    t_lane                 w_cl;
    logic                  w_ovf;

    assign w_en       = ~o_m_tvalid | i_m_tready;
    assign o_s_tready = w_en;

    assign w_arg_s = $signed(A_W'($signed(i_s_tdata))) <<< 28;
    assign w_arg_c = w_arg_s + A_W'(HALFPI_Q52);

    sct_eval #(.TERMS(TERMS)) u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_cmd   (i_s_tuser),
        .i_arg   (w_arg_s),
        .o_valid (w_sv),
        .o_lane  (w_sl)
    );

    sct_eval #(.TERMS(TERMS)) u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_cmd   (i_s_tuser),
        .i_arg   (w_arg_c),
        .o_valid (w_cv),
        .o_lane  (w_cl)
    );

    sct_tan u_tan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv & w_cv),
        .i_cmd   (w_sl.tag),
        .i_sin   (w_sl.sum),
        .i_cos   (w_cl.sum),
        .o_valid (o_m_tvalid),
        .o_value (o_m_tdata),
        .o_ovf   (w_ovf)
    );

    assign o_m_tuser = w_ovf;

endmodule

### design/sct_checker.sv
// ----------------------------------------------------------------------------
// sct_port_checker
// Port-level checks for the sine/cosine/tangent unit, bound to the top.
// ----------------------------------------------------------------------------
module sct_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled transfer changed");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("not ready with empty output");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("accepted during output stall");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tdata == 32'h7FFFFFFF ||
                                        o_m_tdata == 32'h80000000))
        else $error("overflow without saturated value");

endmodule

bind sine_cosine_tangent_unit_top sct_port_checker u_sct_port_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### test/sct_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sct_checker
// Watches both stream channels of the sine/cosine/tangent unit. Computes the
// expected value and overflow flag of every accepted angle with a fixed-point
// Taylor evaluator and compares each output transfer against the oldest one.
// ----------------------------------------------------------------------------
module sct_checker import sct_pkg::*; #(
    parameter int TERMS = TERMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [ANGLE_W-1:0] i_s_tdata,
    input  logic [CMD_W-1:0]   i_s_tuser,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [VALUE_W-1:0] i_m_tdata,
    input  logic [0:0]         i_m_tuser,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } t_result;

    t_result results_q[$];

    function automatic longint round_shift(longint v, int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint taylor_sine_q30(longint a);
        longint r, x, x2, term, sum, d, p;
        r = a % TWOPI_Q52;
        if (r > PI_Q52) r -= TWOPI_Q52;
        else if (r < -PI_Q52) r += TWOPI_Q52;
        if (r > HALFPI_Q52) r = PI_Q52 - r;
        else if (r < -HALFPI_Q52) r = -PI_Q52 - r;
        x = round_shift(r, 22);
        x2 = round_shift(x * x, 30);
        term = x;
        sum = x;
        for (int n = 1; n < TERMS; n++) begin
            d = longint'(2 * n) * longint'(2 * n + 1);
            p = (term * x2) / d;
            term = -round_shift(p, 30);
            sum += term;
        end
        return sum;
    endfunction

    function automatic t_result eval_trig(logic [CMD_W-1:0] cmd, logic [ANGLE_W-1:0] ang);
        longint a52, s, c, q;
        t_result res;
        a52 = longint'($signed(ang)) * 64'sd268435456;
        res = '0;
        if (cmd == CMD_SIN) begin
            res.value = VALUE_W'(round_shift(taylor_sine_q30(a52), 6));
        end else if (cmd == CMD_COS) begin
            res.value = VALUE_W'(round_shift(taylor_sine_q30(a52 + HALFPI_Q52), 6));
        end else if (cmd == CMD_TAN) begin
            s = taylor_sine_q30(a52);
            c = taylor_sine_q30(a52 + HALFPI_Q52);
            if (c == 0) begin
                res.value = (s >= 0) ? 32'h7FFFFFFF : 32'h80000000;
                res.overflow = 1'b1;
            end else begin
                q = (s * 64'sd16777216) / c;
                if (q > 64'sd2147483647) begin
                    q = 64'sd2147483647;
                    res.overflow = 1'b1;
                end else if (q < -64'sd2147483648) begin
                    q = -64'sd2147483648;
                    res.overflow = 1'b1;
                end
                res.value = VALUE_W'(q);
            end
        end
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h expected %h", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            o_errors = 0;
            results_q.delete();
        end
        if (i_rst_n && i_s_tvalid && i_s_tready)
            results_q.push_back(eval_trig(i_s_tuser, i_s_tdata));
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (results_q.size() == 0) begin
                report("unexpected transfer", i_m_tdata, 32'h0);
            end else begin
                want = results_q.pop_front();
                if (i_m_tdata !== want.value) report("value", i_m_tdata, want.value);
                if (i_m_tuser[0] !== want.overflow)
                    report("overflow", 32'(i_m_tuser), 32'(want.overflow));
            end
        end
        o_pending = results_q.size();
    end

endmodule

### test/tb_sine_cosine_tangent_unit_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_tangent_unit_top
// Drives directed and random angle/command transfers into the trig unit with
// random gaps on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sine_cosine_tangent_unit_top;
    import sct_pkg::*;

    localparam int LATENCY  = 8 + 5 * (TERMS_DEF - 1) + 34;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 730;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [ANGLE_W-1:0] s_tdata;
    logic [CMD_W-1:0]   s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;
    logic [0:0]         m_tuser;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    bit                 stalling;

    sine_cosine_tangent_unit_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    sct_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // hold stall mode for stretches; occasionally run with no backpressure
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stalling <= ~stalling;
        if (!i_rst_n) m_tready <= 1'b0;
        else if (!stalling) m_tready <= 1'b1;
        else m_tready <= (gap_len() == 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || s_tvalid && s_tready || m_tvalid && m_tready) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("sine_cosine_tangent_unit_top: mismatch");
            $finish;
        end
    end

    task automatic send(logic [CMD_W-1:0] cmd, logic [ANGLE_W-1:0] ang, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ang;
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [ANGLE_W-1:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return ANGLE_W'($signed($urandom_range(0, 32'h0C90FDAA)) -
                               $signed(32'h06487ED5));
            2: return ANGLE_W'(($urandom_range(0, 1) ? 32'h01921FB5 : 32'h04B65F1F)
                               + $urandom_range(0, 8) - 4);
            3: return ANGLE_W'($signed($urandom_range(0, 2048)) - 1024);
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                                 : 32'h80000000 + $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] CMD_CMD_PICK();
        case ($urandom_range(0, 2))
            0: return CMD_SIN;
            1: return CMD_COS;
            default: return CMD_TAN;
        endcase
    endfunction

    initial begin
        logic [ANGLE_W-1:0] dir_angles[8];
        int wait_cycles;
        dir_angles = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h01921FB5,
                       32'hFE6DE04B, 32'h03243F6A, 32'h00000001, 32'hFFFFFFFF};
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_SIN;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_angles[k]) begin
            send(CMD_SIN, dir_angles[k], 1'b0);
            send(CMD_COS, dir_angles[k], 1'b0);
            send(CMD_TAN, dir_angles[k], 1'b0);
        end
        send(CMD_UNUSED, 32'h01000000, 1'b0);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            send($urandom_range(0, 15) == 0 ? CMD_UNUSED : CMD_CMD_PICK(), rand_angle(),
                 1'b1);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 2 * LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (errors == 0 && pending == 0)
            $display("sine_cosine_tangent_unit_top: match");
        else
            $display("sine_cosine_tangent_unit_top: mismatch");
        $finish;
    end

endmodule
